// ===== rtl/fae_pkg.sv =====
package fae_pkg;

    localparam int PIXEL_W    = 8;
    localparam int EXPOSURE_W = 32;
    localparam int GAIN_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // sum = exposure + err * gain: needs 34 bits signed
    localparam int ERR_W  = PIXEL_W + 1;
    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam int SUM_W  = EXPOSURE_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q8      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_EXPOSURE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXPOSURE = 3'd4;

    localparam logic [STATUS_W-1:0] LIM_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] LIM_MIN  = 2'd1;
    localparam logic [STATUS_W-1:0] LIM_MAX  = 2'd2;

    localparam logic [PIXEL_W-1:0]    RST_TARGET_LEVEL = 8'd200;
    localparam logic [GAIN_W-1:0]     RST_GAIN_Q8      = 16'd307;
    localparam logic [PIXEL_W-1:0]    RST_DEADBAND     = 8'd1;
    localparam logic [EXPOSURE_W-1:0] RST_MIN_EXPOSURE = 32'd3840;
    localparam logic [EXPOSURE_W-1:0] RST_MAX_EXPOSURE = 32'd2560000000;
    localparam logic [EXPOSURE_W-1:0] RST_EXPOSURE     = 32'd76800;

    typedef struct packed {
        logic [EXPOSURE_W-1:0] exposure;
        logic [PIXEL_W-1:0]    frame_peak;
        logic                  updated;
        logic [STATUS_W-1:0]   limit_status;
    } result_t;

endpackage

// ===== rtl/frame_max_auto_exposure_top.sv =====
// Frame-peak auto-exposure controller.
// Throughput: one pixel per cycle while s_ready is high; the peak compare runs on accept.
// A result passes through the frame register, loaded when its frame_end pixel is accepted,
// and then the output register, loaded once that register is free.
// Reset (aresetn low, synchronous): peak cleared, exposure 76800 (300 us),
// registers to their defaults, no result pending.
module frame_max_auto_exposure_top
    import fae_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIXEL_W-1:0]    s_pixel,
    input  logic                  s_frame_end,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [EXPOSURE_W-1:0] m_exposure,
    output logic [PIXEL_W-1:0]    m_frame_peak,
    output logic                  m_updated,
    output logic [STATUS_W-1:0]   m_limit_status
);

    logic [PIXEL_W-1:0]    target_level_reg;
    logic [GAIN_W-1:0]     gain_q8_reg;
    logic [PIXEL_W-1:0]    deadband_reg;
    logic [EXPOSURE_W-1:0] min_exposure_reg;
    logic [EXPOSURE_W-1:0] max_exposure_reg;

    logic [PIXEL_W-1:0]    running_peak_reg;
    logic [PIXEL_W-1:0]    running_peak_next;
    logic [EXPOSURE_W-1:0] exposure_reg;
    logic [EXPOSURE_W-1:0] exposure_next;

    logic                  frame_valid_reg;
    logic [PIXEL_W-1:0]    frame_peak_reg;

    logic                  out_valid_reg;
    result_t               out_reg;
    result_t               result_next;

    logic                  s_fire;
    logic                  out_free;
    logic                  frame_move;

    logic signed [ERR_W-1:0]  err;
    logic [PIXEL_W-1:0]       err_mag;
    logic signed [PROD_W-1:0] step;
    logic signed [SUM_W-1:0]  sum;
    logic                     apply;

    assign out_free   = !out_valid_reg || m_ready;
    assign frame_move = frame_valid_reg && out_free;
    assign s_ready    = !frame_valid_reg || out_free;
    assign s_fire     = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_level_reg <= RST_TARGET_LEVEL;
            gain_q8_reg      <= RST_GAIN_Q8;
            deadband_reg     <= RST_DEADBAND;
            min_exposure_reg <= RST_MIN_EXPOSURE;
            max_exposure_reg <= RST_MAX_EXPOSURE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TARGET_LEVEL: target_level_reg <= cfg_wdata[PIXEL_W-1:0];
                CFG_GAIN_Q8:      gain_q8_reg      <= cfg_wdata[GAIN_W-1:0];
                CFG_DEADBAND:     deadband_reg     <= cfg_wdata[PIXEL_W-1:0];
                CFG_MIN_EXPOSURE: min_exposure_reg <= cfg_wdata[EXPOSURE_W-1:0];
                CFG_MAX_EXPOSURE: max_exposure_reg <= cfg_wdata[EXPOSURE_W-1:0];
                default: ;
            endcase
        end
    end

    // peak tracking on accept; last pixel of a frame hands the peak on
    always_comb begin
        running_peak_next = (s_pixel > running_peak_reg) ? s_pixel : running_peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_peak_reg <= '0;
            frame_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                running_peak_reg <= s_frame_end ? '0 : running_peak_next;
            end
            if (s_fire && s_frame_end) begin
                frame_valid_reg <= 1'b1;
            end else if (frame_move) begin
                frame_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_frame_end) begin
            frame_peak_reg <= running_peak_next;
        end
    end

    // error, proportional step and saturation
    always_comb begin
        err     = $signed({1'b0, target_level_reg}) - $signed({1'b0, frame_peak_reg});
        err_mag = err[ERR_W-1] ? PIXEL_W'(-err) : err[PIXEL_W-1:0];
        apply   = (err_mag >= deadband_reg);
        step    = PROD_W'(err) * $signed({1'b0, gain_q8_reg});
        sum     = $signed({2'b00, exposure_reg}) + SUM_W'(step);

        exposure_next            = exposure_reg;
        result_next.frame_peak   = frame_peak_reg;
        result_next.updated      = apply;
        result_next.limit_status = LIM_NONE;
        if (apply) begin
            if (sum < $signed({2'b00, min_exposure_reg})) begin
                exposure_next            = min_exposure_reg;
                result_next.limit_status = LIM_MIN;
            end else if (sum > $signed({2'b00, max_exposure_reg})) begin
                exposure_next            = max_exposure_reg;
                result_next.limit_status = LIM_MAX;
            end else begin
                exposure_next = sum[EXPOSURE_W-1:0];
            end
        end
        result_next.exposure = exposure_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exposure_reg  <= RST_EXPOSURE;
            out_valid_reg <= 1'b0;
        end else begin
            if (frame_move) begin
                exposure_reg  <= exposure_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_move) begin
            out_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_exposure     = out_reg.exposure;
    assign m_frame_peak   = out_reg.frame_peak;
    assign m_updated      = out_reg.updated;
    assign m_limit_status = out_reg.limit_status;

    // deadband result carries no limit flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_updated |-> m_limit_status == LIM_NONE)
        else $error("deadband result with limit status");

    // exposure state only moves on an applied update
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(frame_move && apply) |=> $stable(exposure_reg))
        else $error("exposure changed without update");

    // peak is cleared after the last pixel of a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_frame_end |=> running_peak_reg == '0 && frame_valid_reg)
        else $error("frame end not handed on");

    // max-clamped result matches the limit it reports
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_move && result_next.limit_status == LIM_MAX
        |=> m_exposure == max_exposure_reg && exposure_reg == max_exposure_reg)
        else $error("max clamp mismatch");

    // output value always mirrors the exposure state right after a move
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_move |=> m_valid && m_exposure == exposure_reg)
        else $error("output exposure differs from state");

endmodule

// ===== tb/frame_max_auto_exposure_top_test.sv =====
`timescale 1ns / 100ps

module frame_max_auto_exposure_top_test;
    import fae_pkg::*;

    localparam int     RESULT_LATENCY = 1;
    localparam int     STALL_LIMIT    = 4000;
    localparam int     IDLE_PCT       = 16;
    localparam int     PHASE_ITEMS    = 125;
    localparam int     RANDOM_PHASES  = 10;
    localparam longint EXPOSURE_CEIL  = 64'h0000_0000_FFFF_FFFF;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [PIXEL_W-1:0]    s_pixel     = '0;
    logic                  s_frame_end = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [EXPOSURE_W-1:0] m_exposure;
    logic [PIXEL_W-1:0]    m_frame_peak;
    logic                  m_updated;
    logic [STATUS_W-1:0]   m_limit_status;

    // register mirror and controller state
    logic [PIXEL_W-1:0]    cfg_target;
    logic [GAIN_W-1:0]     cfg_gain;
    logic [PIXEL_W-1:0]    cfg_deadband;
    logic [EXPOSURE_W-1:0] cfg_min_exp;
    logic [EXPOSURE_W-1:0] cfg_max_exp;
    logic [PIXEL_W-1:0]    peak_so_far;
    logic [EXPOSURE_W-1:0] exposure_now;

    result_t pending_reports[$];

    bit no_idle = 1'b0;
    int errors          = 0;
    int pixels_sent     = 0;
    int frames_checked  = 0;
    int regs_written    = 0;
    int clamped_low     = 0;
    int clamped_high    = 0;
    int held_frames     = 0;
    int quiet_cycles    = 0;

    frame_max_auto_exposure_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel        (s_pixel),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_exposure     (m_exposure),
        .m_frame_peak   (m_frame_peak),
        .m_updated      (m_updated),
        .m_limit_status (m_limit_status)
    );

    always #6 aclk = ~aclk;

    function automatic void reset_exposure_model();
        cfg_target   = RST_TARGET_LEVEL;
        cfg_gain     = RST_GAIN_Q8;
        cfg_deadband = RST_DEADBAND;
        cfg_min_exp  = RST_MIN_EXPOSURE;
        cfg_max_exp  = RST_MAX_EXPOSURE;
        peak_so_far  = '0;
        exposure_now = RST_EXPOSURE;
    endfunction

    function automatic void advance_exposure_model(input logic [PIXEL_W-1:0] pix,
                                                   input logic last);
        int      err;
        longint  sum;
        result_t rpt;
        if (pix > peak_so_far)
            peak_so_far = pix;
        if (!last)
            return;
        err = int'(cfg_target) - int'(peak_so_far);
        rpt.frame_peak   = peak_so_far;
        rpt.updated      = 1'b0;
        rpt.limit_status = LIM_NONE;
        if ((err < 0 ? -err : err) >= int'(cfg_deadband)) begin
            sum = longint'({32'd0, exposure_now}) + longint'(err) * longint'({48'd0, cfg_gain});
            rpt.updated = 1'b1;
            // min is checked first so crossed limits resolve to the minimum
            if (sum < longint'({32'd0, cfg_min_exp})) begin
                exposure_now     = cfg_min_exp;
                rpt.limit_status = LIM_MIN;
            end else if (sum > longint'({32'd0, cfg_max_exp})) begin
                exposure_now     = cfg_max_exp;
                rpt.limit_status = LIM_MAX;
            end else begin
                exposure_now = sum[EXPOSURE_W-1:0];
            end
        end
        rpt.exposure = exposure_now;
        pending_reports.push_back(rpt);
        peak_so_far = '0;
    endfunction

    // entered and left just after a falling edge
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel     <= pix;
        s_frame_end <= last;
        do @(posedge aclk); while (!s_ready);
        advance_exposure_model(pix, last);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_TARGET_LEVEL: cfg_target   = data[PIXEL_W-1:0];
            CFG_GAIN_Q8:      cfg_gain     = data[GAIN_W-1:0];
            CFG_DEADBAND:     cfg_deadband = data[PIXEL_W-1:0];
            CFG_MIN_EXPOSURE: cfg_min_exp  = data;
            CFG_MAX_EXPOSURE: cfg_max_exp  = data;
            default: ;
        endcase
        regs_written++;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // stop sending, let every pending report drain, then give the pipe time to empty
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge aclk);
        repeat (RESULT_LATENCY + 4) @(negedge aclk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    always @(negedge aclk)
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t ns: unexpected report, expected none, actual exposure %0d peak %0d",
                         $time, m_exposure, m_frame_peak);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (m_exposure !== want.exposure)
                    report_mismatch("exposure", want.exposure, m_exposure);
                if (m_frame_peak !== want.frame_peak)
                    report_mismatch("frame_peak", want.frame_peak, m_frame_peak);
                if (m_updated !== want.updated)
                    report_mismatch("updated", want.updated, m_updated);
                if (m_limit_status !== want.limit_status)
                    report_mismatch("limit_status", want.limit_status, m_limit_status);
                frames_checked++;
                if (!want.updated)
                    held_frames++;
                if (want.limit_status == LIM_MIN)
                    clamped_low++;
                if (want.limit_status == LIM_MAX)
                    clamped_high++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("frame_max_auto_exposure_top test failed");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_pixel(8'd200, 1'b1);   // error zero: held
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd255, 1'b1);   // too bright, exposure drops
        send_pixel(8'd0, 1'b1);     // dark frame, exposure rises
        send_pixel(8'd255, 1'b0);   // peak on the first pixel
        send_pixel(8'd3, 1'b0);
        send_pixel(8'd7, 1'b1);
        send_pixel(8'd199, 1'b1);   // |error| equals deadband: applied
    endtask

    task automatic test_deadband_and_gain();
        settle();
        write_reg(CFG_DEADBAND, 32'd0);
        write_reg(CFG_TARGET_LEVEL, 32'd100);
        send_pixel(8'd100, 1'b1);   // zero error still flagged as update
        settle();
        write_reg(CFG_GAIN_Q8, 32'd0);
        send_pixel(8'd0, 1'b1);     // update with no movement
        settle();
        write_reg(CFG_GAIN_Q8, 32'd307);
        write_reg(CFG_DEADBAND, 32'd255);
        write_reg(CFG_TARGET_LEVEL, 32'd255);
        send_pixel(8'd0, 1'b1);     // only full-scale error passes the band
        send_pixel(8'd1, 1'b1);
        settle();
        write_reg(CFG_TARGET_LEVEL, 32'd0);
        send_pixel(8'd255, 1'b1);
    endtask

    task automatic test_limit_clamps();
        settle();
        write_reg(CFG_DEADBAND, 32'd0);
        write_reg(CFG_GAIN_Q8, 32'hFFFF);
        write_reg(CFG_MIN_EXPOSURE, 32'd50000);
        write_reg(CFG_MAX_EXPOSURE, 32'd100000);
        write_reg(CFG_TARGET_LEVEL, 32'd255);
        send_pixel(8'd0, 1'b1);     // clamp high
        settle();
        write_reg(CFG_TARGET_LEVEL, 32'd0);
        send_pixel(8'd255, 1'b1);   // clamp low
        settle();
        // crossed limits
        write_reg(CFG_MIN_EXPOSURE, 32'd200000);
        send_pixel(8'd255, 1'b1);
        settle();
        write_reg(CFG_TARGET_LEVEL, 32'd255);
        send_pixel(8'd0, 1'b1);
        settle();
        write_reg(CFG_MIN_EXPOSURE, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_EXPOSURE, 32'hFFFF_FFFF);
        send_pixel(8'd0, 1'b1);     // clamps to the 32-bit top so the next sum passes 32 bits and must not wrap
        settle();
        write_reg(CFG_MIN_EXPOSURE, 32'd0);
        send_pixel(8'd0, 1'b1);
        settle();
        write_reg(CFG_TARGET_LEVEL, 32'd0);
        send_pixel(8'd255, 1'b1);
    endtask

    task automatic test_unused_index();
        settle();
        for (int idx = CFG_MAX_EXPOSURE + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(idx[CFG_IDX_W-1:0], 32'hFFFF_FFFF);
        send_pixel(8'd128, 1'b1);
    endtask

    task automatic pick_random_settings();
        logic [31:0] word;
        longint      lo_lim;
        longint      hi_lim;
        longint      span;
        word = $urandom();
        case ($urandom_range(0, 3))
            0:       word[7:0] = 8'd0;
            1:       word[7:0] = 8'd255;
            default: word[7:0] = 8'($urandom_range(0, 255));
        endcase
        write_reg(CFG_TARGET_LEVEL, word);
        word = $urandom();
        case ($urandom_range(0, 4))
            0:       word[15:0] = 16'd0;
            1:       word[15:0] = 16'hFFFF;
            2:       word[15:0] = 16'($urandom_range(0, 1023));
            default: ;
        endcase
        write_reg(CFG_GAIN_Q8, word);
        word = $urandom();
        case ($urandom_range(0, 4))
            0:       word[7:0] = 8'd0;
            1:       word[7:0] = 8'd255;
            2, 3:    word[7:0] = 8'($urandom_range(0, 8));
            default: ;
        endcase
        write_reg(CFG_DEADBAND, word);
        case ($urandom_range(0, 4))
            0: begin
                lo_lim = RST_MIN_EXPOSURE;
                hi_lim = RST_MAX_EXPOSURE;
            end
            1: begin
                lo_lim = 0;
                hi_lim = EXPOSURE_CEIL;
            end
            2: begin
                // window around the present value so both clamps and free steps occur
                span   = $urandom_range(1000, 400000);
                lo_lim = longint'({32'd0, exposure_now}) - span;
                hi_lim = longint'({32'd0, exposure_now}) + span;
            end
            3: begin
                hi_lim = $urandom_range(0, 32'h7FFF_FFFF);
                lo_lim = hi_lim + $urandom_range(1, 1000000);
            end
            default: begin
                lo_lim = $urandom();
                hi_lim = lo_lim + $urandom();
            end
        endcase
        if (lo_lim < 0)
            lo_lim = 0;
        if (hi_lim > EXPOSURE_CEIL)
            hi_lim = EXPOSURE_CEIL;
        write_reg(CFG_MIN_EXPOSURE, lo_lim[31:0]);
        write_reg(CFG_MAX_EXPOSURE, hi_lim[31:0]);
    endtask

    task automatic send_random_frame();
        int len;
        int hot;
        int lo;
        int hi;
        int pk;
        logic [PIXEL_W-1:0] pix;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0: pk = $urandom_range(0, 255);
            1: begin
                // peak near the target, straddling the deadband edge
                lo = int'(cfg_target) - int'(cfg_deadband) - 2;
                hi = int'(cfg_target) + int'(cfg_deadband) + 2;
                if (lo < 0)
                    lo = 0;
                if (hi > 255)
                    hi = 255;
                pk = $urandom_range(lo, hi);
            end
            2: pk = $urandom_range(0, 1) ? 255 : 0;
            default: pk = -1;
        endcase
        hot = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            if (pk < 0)
                pix = PIXEL_W'($urandom_range(0, 255));
            else if (i == hot)
                pix = PIXEL_W'(pk);
            else
                pix = PIXEL_W'($urandom_range(0, pk));
            send_pixel(pix, i == len - 1);
        end
    endtask

    task automatic test_random_frames();
        int quota;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            no_idle = (phase == 3);
            pick_random_settings();
            quota = pixels_sent + PHASE_ITEMS;
            for (int f = 0; pixels_sent < quota; f++) begin
                send_random_frame();
                if (f == 1)
                    settle();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        reset_exposure_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_deadband_and_gain();
        test_limit_clamps();
        test_unused_index();
        test_random_frames();
        settle();
        $display("Sent %0d pixels, checked %0d frame reports across %0d register writes.",
                 pixels_sent, frames_checked, regs_written);
        $display("Reports held in deadband %0d, clamped low %0d, clamped high %0d.",
                 held_frames, clamped_low, clamped_high);
        if (errors == 0) begin
            $display("frame_max_auto_exposure_top test passed");
        end else begin
            $display("frame_max_auto_exposure_top test failed");
        end
        $finish;
    end

endmodule
